@@ sv/segment_lcd_temperature_formatter_core_defines.svh @@
// Assertion macros shared by the checker of the segment LCD formatter.
`ifndef SEGMENT_LCD_TEMPERATURE_FORMATTER_CORE_DEFINES_SVH
`define SEGMENT_LCD_TEMPERATURE_FORMATTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SEGFMT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segfmt: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SEGFMT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segfmt: next-cycle check failed");

`endif

@@ sv/segfmt_pkg.sv @@
// Shared types and constants of the segment LCD temperature formatter.
package segfmt_pkg;

    localparam int TEMP_W   = 16;
    localparam int LEVEL_W  = 3;
    localparam int ADDR_W   = 4;
    localparam int NIBBLE_W = 4;
    localparam int DIGIT_W  = 4;
    localparam int MAG_W    = 14;

    localparam logic [MAG_W-1:0] MAG_MAX = 14'd9999;

    localparam int DESC_QUEUE_DEPTH = 2;
    localparam int OUT_QUEUE_DEPTH  = 2;

    // Classified update: sign, battery level, snapshot of config and blink phase, digits.
    typedef struct packed {
        logic               neg;
        logic [LEVEL_W-1:0] level;
        logic               unit_point;
        logic               phase;
        logic [DIGIT_W-1:0] d4;
        logic [DIGIT_W-1:0] d3;
        logic [DIGIT_W-1:0] d2;
        logic [DIGIT_W-1:0] d1;
    } desc_t;

    // One nibble write toward the segment controller.
    typedef struct packed {
        logic [ADDR_W-1:0]   address;
        logic [NIBBLE_W-1:0] nibble;
        logic                last;
    } wr_t;

endpackage

@@ sv/segment_lcd_temperature_formatter_core.sv @@
// Top level of the segment LCD temperature formatter.
//
// Input channel: push/full with temp_tenths (signed tenths of a degree) and
// battery_level. Each accepted update becomes 14 to 18 nibble writes on the
// result channel (empty/pop with write_address, write_nibble, last_write),
// oldest first; last_write marks the final write of an update.
// cfg_write/cfg_data set the unit mark enable; write it only while idle.
// The first write of an update reaches the result ports through the input
// stage, two digit stages, the classified-update queue and the result queue.
// Throughput: at most one write per cycle, while the result queue has room;
// the slot walker steps through every write slot, disabled ones included,
// up to the last write of the update, which sets the sustained rate.
// Updates queue in the front while the walker works.
// Reset empties both queues, clears the blink phase and sets the unit mark
// enable. A receiver that holds pop low keeps the current write on the ports;
// the walker and then the front stall behind the full queues, and full rises.
module segment_lcd_temperature_formatter_core
    import segfmt_pkg::*;
#(
    parameter int DESC_DEPTH = DESC_QUEUE_DEPTH,
    parameter int OUT_DEPTH  = OUT_QUEUE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic                      cfg_data,
    input  logic                      push,
    output logic                      full,
    input  logic signed [TEMP_W-1:0]  temp_tenths,
    input  logic [LEVEL_W-1:0]        battery_level,
    output logic                      empty,
    input  logic                      pop,
    output logic [ADDR_W-1:0]         write_address,
    output logic [NIBBLE_W-1:0]       write_nibble,
    output logic                      last_write
);

    desc_t desc_in;
    desc_t desc_out;
    logic  desc_push;
    logic  desc_full;
    logic  desc_empty;
    logic  desc_pop;
    wr_t   wr_in;
    wr_t   wr_out;
    logic  wr_push;
    logic  wr_full;

    segfmt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .temp_tenths   (temp_tenths),
        .battery_level (battery_level),
        .desc_push     (desc_push),
        .desc          (desc_in),
        .desc_full     (desc_full)
    );

    segfmt_queue #(
        .WIDTH ($bits(desc_t)),
        .DEPTH (DESC_DEPTH)
    ) u_desc_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (desc_push),
        .wdata (desc_in),
        .full  (desc_full),
        .pop   (desc_pop),
        .rdata (desc_out),
        .empty (desc_empty)
    );

    segfmt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc       (desc_out),
        .desc_empty (desc_empty),
        .desc_pop   (desc_pop),
        .wr         (wr_in),
        .wr_push    (wr_push),
        .wr_full    (wr_full)
    );

    segfmt_queue #(
        .WIDTH ($bits(wr_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (wr_push),
        .wdata (wr_in),
        .full  (wr_full),
        .pop   (pop),
        .rdata (wr_out),
        .empty (empty)
    );

    assign write_address = wr_out.address;
    assign write_nibble  = wr_out.nibble;
    assign last_write    = wr_out.last;

endmodule

@@ sv/segfmt_queue.sv @@
// Small register queue used between the formatter stages and at the result side.
module segfmt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wptr_reg, wptr_next;
    logic [AW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

endmodule

@@ sv/segfmt_front.sv @@
// Front end: takes updates, saturates the magnitude and splits it into decimal digits.
module segfmt_front
    import segfmt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic                      cfg_data,
    input  logic                      push,
    output logic                      full,
    input  logic signed [TEMP_W-1:0]  temp_tenths,
    input  logic [LEVEL_W-1:0]        battery_level,
    output logic                      desc_push,
    output desc_t                     desc,
    input  logic                      desc_full
);

    localparam logic [MAG_W-1:0] UNIT_THOUSAND = 14'd1000;
    localparam logic [MAG_W-1:0] UNIT_HUNDRED  = 14'd100;
    localparam logic [MAG_W-1:0] UNIT_TEN      = 14'd10;

    // Largest k in 0..9 with k*unit <= v; the compares are independent.
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [MAG_W-1:0] v,
                                                    input logic [MAG_W-1:0] unit);
        logic [DIGIT_W-1:0] d;
        d = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (v >= MAG_W'(k) * unit)
            begin
                d = DIGIT_W'(k);
            end
        end
        return d;
    endfunction

    logic                 unit_point_reg;
    logic                 phase_reg;

    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                 adv1, adv2, adv3;

    logic [TEMP_W-1:0]    raw;
    logic [TEMP_W-1:0]    mag_abs;
    logic [MAG_W-1:0]     mag_sat;

    logic                 s1_neg_reg;
    logic [LEVEL_W-1:0]   s1_level_reg;
    logic                 s1_upe_reg;
    logic                 s1_phase_reg;
    logic [MAG_W-1:0]     s1_mag_reg;

    logic                 s2_neg_reg;
    logic [LEVEL_W-1:0]   s2_level_reg;
    logic                 s2_upe_reg;
    logic                 s2_phase_reg;
    logic [DIGIT_W-1:0]   s2_d4_reg;
    logic [9:0]           s2_rem_reg;
    logic [DIGIT_W-1:0]   s2_d4_next;
    logic [9:0]           s2_rem_next;

    logic                 s3_neg_reg;
    logic [LEVEL_W-1:0]   s3_level_reg;
    logic                 s3_upe_reg;
    logic                 s3_phase_reg;
    logic [DIGIT_W-1:0]   s3_d4_reg;
    logic [DIGIT_W-1:0]   s3_d3_reg;
    logic [6:0]           s3_rem_reg;
    logic [DIGIT_W-1:0]   s3_d3_next;
    logic [6:0]           s3_rem_next;

    logic [DIGIT_W-1:0]   d2;
    logic [DIGIT_W-1:0]   d1;

    // Stall chain: a stage loads when it is empty or its successor loads.
    assign adv3 = !s3_valid_reg || !desc_full;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;
    assign full = !adv1;

    assign raw     = temp_tenths;
    assign mag_abs = raw[TEMP_W-1] ? (~raw + 16'd1) : raw;
    assign mag_sat = (mag_abs > TEMP_W'(MAG_MAX)) ? MAG_MAX : mag_abs[MAG_W-1:0];

    always_comb
    begin
        s2_d4_next  = digit_of(s1_mag_reg, UNIT_THOUSAND);
        s2_rem_next = 10'(s1_mag_reg - MAG_W'(s2_d4_next) * UNIT_THOUSAND);
        s3_d3_next  = digit_of(MAG_W'(s2_rem_reg), UNIT_HUNDRED);
        s3_rem_next = 7'(MAG_W'(s2_rem_reg) - MAG_W'(s3_d3_next) * UNIT_HUNDRED);
        d2          = digit_of(MAG_W'(s3_rem_reg), UNIT_TEN);
        d1          = DIGIT_W'(MAG_W'(s3_rem_reg) - MAG_W'(d2) * UNIT_TEN);
    end

    assign desc_push       = s3_valid_reg && !desc_full;
    assign desc.neg        = s3_neg_reg;
    assign desc.level      = s3_level_reg;
    assign desc.unit_point = s3_upe_reg;
    assign desc.phase      = s3_phase_reg;
    assign desc.d4         = s3_d4_reg;
    assign desc.d3         = s3_d3_reg;
    assign desc.d2         = d2;
    assign desc.d1         = d1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_point_reg <= 1'b1;
            phase_reg      <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unit_point_reg <= cfg_data;
            end
            // Flip the blink phase once per accepted update.
            if (push && adv1)
            begin
                phase_reg <= ~phase_reg;
            end
            if (adv1)
            begin
                s1_valid_reg <= push;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && adv1)
        begin
            s1_neg_reg   <= raw[TEMP_W-1];
            s1_level_reg <= battery_level;
            s1_upe_reg   <= unit_point_reg;
            s1_phase_reg <= phase_reg;
            s1_mag_reg   <= mag_sat;
        end
        if (adv2)
        begin
            s2_neg_reg   <= s1_neg_reg;
            s2_level_reg <= s1_level_reg;
            s2_upe_reg   <= s1_upe_reg;
            s2_phase_reg <= s1_phase_reg;
            s2_d4_reg    <= s2_d4_next;
            s2_rem_reg   <= s2_rem_next;
        end
        if (adv3)
        begin
            s3_neg_reg   <= s2_neg_reg;
            s3_level_reg <= s2_level_reg;
            s3_upe_reg   <= s2_upe_reg;
            s3_phase_reg <= s2_phase_reg;
            s3_d4_reg    <= s2_d4_reg;
            s3_d3_reg    <= s3_d3_next;
            s3_rem_reg   <= s3_rem_next;
        end
    end

endmodule

@@ sv/segfmt_back.sv @@
// Back end: walks the write slots of one update and issues one nibble write per cycle while wr_full is low.
module segfmt_back
    import segfmt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  desc_t desc,
    input  logic  desc_empty,
    output logic  desc_pop,
    output wr_t   wr,
    output logic  wr_push,
    input  logic  wr_full
);

    localparam int SLOTS  = 18;
    localparam int SLOT_W = 5;

    localparam logic [SLOT_W-1:0] SLOT_BATTERY   = 5'd9;
    localparam logic [SLOT_W-1:0] SLOT_TENTHS_HI = 5'd10;
    localparam logic [SLOT_W-1:0] SLOT_TENTHS_LO = 5'd11;
    localparam logic [SLOT_W-1:0] SLOT_UNITS_HI  = 5'd12;
    localparam logic [SLOT_W-1:0] SLOT_UNITS_LO  = 5'd13;
    localparam logic [SLOT_W-1:0] SLOT_TENS_A    = 5'd14;
    localparam logic [SLOT_W-1:0] SLOT_TENS_B    = 5'd15;
    localparam logic [SLOT_W-1:0] SLOT_HUND_HI   = 5'd16;
    localparam logic [SLOT_W-1:0] SLOT_HUND_LO   = 5'd17;

    localparam logic [ADDR_W-1:0] ADDR_HUND    = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_TENS    = 4'd2;
    localparam logic [ADDR_W-1:0] ADDR_UNITS   = 4'd4;
    localparam logic [ADDR_W-1:0] ADDR_TENTHS  = 4'd6;
    localparam logic [ADDR_W-1:0] ADDR_BATTERY = 4'd8;

    localparam logic [NIBBLE_W-1:0] MARK_NIB  = 4'h1;
    localparam logic [NIBBLE_W-1:0] MINUS_NIB = 4'h4;
    localparam logic [NIBBLE_W-1:0] ICON_NIB  = 4'h8;

    localparam logic [LEVEL_W-1:0] LEVEL_BLINK = 3'd5;

    function automatic logic [7:0] seg_pattern(input logic [DIGIT_W-1:0] d);
        logic [7:0] p;
        case (d)
            4'd0:    p = 8'hAF;
            4'd1:    p = 8'h06;
            4'd2:    p = 8'hCB;
            4'd3:    p = 8'h4F;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6D;
            4'd6:    p = 8'hED;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'hEF;
            4'd9:    p = 8'h6F;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [SLOTS-1:0]    en_mask;
    logic [SLOTS-1:0]    rest;
    logic                cur_en;
    logic                cur_last;
    logic                adv;
    logic [ADDR_W-1:0]   cur_addr;
    logic [NIBBLE_W-1:0] cur_nib;
    logic [NIBBLE_W-1:0] bar_nib;
    logic [7:0]          pat1, pat2, pat3, pat4;
    logic                blank_tens;
    logic                blink;
    logic                p1;
    logic                tens_mark;

    always_comb
    begin
        pat1       = seg_pattern(desc.d1);
        pat2       = seg_pattern(desc.d2);
        pat3       = seg_pattern(desc.d3);
        pat4       = seg_pattern(desc.d4);
        blank_tens = (desc.d4 == '0) && (desc.d3 == '0);
        blink      = (desc.level == LEVEL_BLINK);
        p1         = (desc.level >= 3'd1) && (desc.level <= 3'd4);
        tens_mark  = !blink || desc.phase;

        case (desc.level)
            3'd2:    bar_nib = ICON_NIB | 4'h1;
            3'd3:    bar_nib = ICON_NIB | 4'h3;
            3'd4:    bar_nib = ICON_NIB | 4'h7;
            default: bar_nib = ICON_NIB;
        endcase

        en_mask        = '0;
        en_mask[8:0]   = '1;
        en_mask[SLOT_BATTERY]   = (desc.level <= LEVEL_BLINK);
        en_mask[SLOT_TENTHS_HI] = 1'b1;
        en_mask[SLOT_TENTHS_LO] = 1'b1;
        en_mask[SLOT_UNITS_HI]  = 1'b1;
        en_mask[SLOT_UNITS_LO]  = 1'b1;
        // Blank tens: the mark write drops out at level five while the blink phase is set.
        en_mask[SLOT_TENS_A]    = !blank_tens || !blink || !desc.phase;
        en_mask[SLOT_TENS_B]    = !blank_tens || (desc.neg && blink);
        en_mask[SLOT_HUND_HI]   = (desc.d4 != '0) || (desc.neg && desc.d3 != '0) || p1;
        en_mask[SLOT_HUND_LO]   = (desc.d4 != '0);

        cur_addr = '0;
        cur_nib  = '0;
        case (slot_reg)
            5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8:
            begin
                cur_addr = slot_reg[ADDR_W-1:0];
                cur_nib  = '0;
            end
            SLOT_BATTERY:
            begin
                cur_addr = ADDR_BATTERY;
                cur_nib  = bar_nib;
            end
            SLOT_TENTHS_HI:
            begin
                cur_addr = ADDR_TENTHS;
                cur_nib  = pat1[7:4] | MARK_NIB;
            end
            SLOT_TENTHS_LO:
            begin
                cur_addr = ADDR_TENTHS + 4'd1;
                cur_nib  = pat1[3:0];
            end
            SLOT_UNITS_HI:
            begin
                cur_addr = ADDR_UNITS;
                cur_nib  = pat2[7:4] | (desc.unit_point ? MARK_NIB : 4'h0);
            end
            SLOT_UNITS_LO:
            begin
                cur_addr = ADDR_UNITS + 4'd1;
                cur_nib  = pat2[3:0];
            end
            SLOT_TENS_A:
            begin
                cur_addr = ADDR_TENS;
                if (!blank_tens)
                begin
                    cur_nib = pat3[7:4] | (tens_mark ? MARK_NIB : 4'h0);
                end
                else if (desc.neg)
                begin
                    cur_nib = MINUS_NIB | MARK_NIB;
                end
                else
                begin
                    cur_nib = MARK_NIB;
                end
            end
            SLOT_TENS_B:
            begin
                // Blank negative tens rewrites the same address with minus alone.
                if (!blank_tens)
                begin
                    cur_addr = ADDR_TENS + 4'd1;
                    cur_nib  = pat3[3:0];
                end
                else
                begin
                    cur_addr = ADDR_TENS;
                    cur_nib  = MINUS_NIB;
                end
            end
            SLOT_HUND_HI:
            begin
                cur_addr = ADDR_HUND;
                if (desc.d4 != '0)
                begin
                    cur_nib = pat4[7:4] | (p1 ? MARK_NIB : 4'h0);
                end
                else if (desc.neg && desc.d3 != '0)
                begin
                    cur_nib = MINUS_NIB | (p1 ? MARK_NIB : 4'h0);
                end
                else
                begin
                    cur_nib = MARK_NIB;
                end
            end
            SLOT_HUND_LO:
            begin
                cur_addr = ADDR_HUND + 4'd1;
                cur_nib  = pat4[3:0];
            end
            default:
            begin
                cur_addr = '0;
                cur_nib  = '0;
            end
        endcase

        cur_en   = en_mask[slot_reg];
        rest     = en_mask >> slot_reg;
        cur_last = cur_en && (rest[SLOTS-1:1] == '0);
        // Step past a disabled slot without waiting for room; hold an enabled one until the queue has room.
        adv      = !desc_empty && (!cur_en || !wr_full);
        wr_push  = !desc_empty && cur_en && !wr_full;
        desc_pop = adv && cur_last;

        slot_next = slot_reg;
        if (adv)
        begin
            slot_next = cur_last ? '0 : slot_reg + 5'd1;
        end
    end

    assign wr.address = cur_addr;
    assign wr.nibble  = cur_nib;
    assign wr.last    = cur_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

@@ sv/segfmt_checker.sv @@
// Port-level checker of the segment LCD formatter and its bind to the top level.
`include "segment_lcd_temperature_formatter_core_defines.svh"

module segfmt_checker
    import segfmt_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     pop,
    input logic                     empty,
    input logic [ADDR_W-1:0]        write_address,
    input logic [NIBBLE_W-1:0]      write_nibble,
    input logic                     last_write
);

    // Position of the shown write within its update, saturating.
    logic [4:0] pos_reg, pos_next;

    always_comb
    begin
        pos_next = pos_reg;
        if (pop && !empty)
        begin
            if (last_write)
            begin
                pos_next = '0;
            end
            else if (pos_reg != 5'd31)
            begin
                pos_next = pos_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    `SEGFMT_ASSERT_NXT(a_stall_hold, !empty && !pop,
        !empty && $stable(write_address) && $stable(write_nibble) && $stable(last_write))

    `SEGFMT_ASSERT_IMP(a_clear_first, !empty && pos_reg < 5'd9,
        write_address == pos_reg[3:0] && write_nibble == 4'h0)

    `SEGFMT_ASSERT_IMP(a_battery_icon, !empty && pos_reg >= 5'd9 && write_address == 4'd8,
        write_nibble[3])

    `SEGFMT_ASSERT_IMP(a_last_late, !empty && last_write, pos_reg >= 5'd10)

endmodule

bind segment_lcd_temperature_formatter_core segfmt_checker u_checker (.*);

@@ verif/tb.sv @@
// Self-checking testbench for the segment LCD temperature formatter core.
module tb;
    import segfmt_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [7:0] MARK_BIT  = 8'h10;
    localparam logic [7:0] MINUS_BIT = 8'h40;
    localparam logic [7:0] ICON_BIT  = 8'h80;
    localparam logic [7:0] BAR_ONE   = 8'h10;
    localparam logic [7:0] BAR_TWO   = 8'h30;
    localparam logic [7:0] BAR_THREE = 8'h70;

    localparam logic [LEVEL_W-1:0] LEVEL_EMPTY = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_TWO   = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_THREE = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_FOUR  = 3'd4;
    localparam logic [LEVEL_W-1:0] LEVEL_BLINK = 3'd5;

    localparam logic [7:0] SEG_TABLE [10] = '{
        8'hAF, 8'h06, 8'hCB, 8'h4F, 8'h66, 8'h6D, 8'hED, 8'h07, 8'hEF, 8'h6F
    };

    typedef enum logic [1:0] {POP_ALWAYS, POP_RANDOM, POP_LONG_STALLS, POP_TOGGLE} pop_style_e;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic                     cfg_data = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic signed [TEMP_W-1:0] temp_tenths = '0;
    logic [LEVEL_W-1:0]       battery_level = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic [ADDR_W-1:0]        write_address;
    logic [NIBBLE_W-1:0]      write_nibble;
    logic                     last_write;

    // Model state and the writes still owed by the block.
    logic       unit_mark_en;
    logic       blink_phase_q;
    wr_t        update_writes [$];
    wr_t        pending_writes [$];
    wr_t        oldest_write;

    int         error_count = 0;
    int         cycle_count = 0;
    int         burst_left = 0;
    bit         sender_steady = 1'b0;

    pop_style_e pop_style = POP_ALWAYS;
    int         style_left = 0;
    int         stall_left = 0;

    segment_lcd_temperature_formatter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .temp_tenths   (temp_tenths),
        .battery_level (battery_level),
        .empty         (empty),
        .pop           (pop),
        .write_address (write_address),
        .write_nibble  (write_nibble),
        .last_write    (last_write)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d writes outstanding",
                     cycle_count, pending_writes.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[cycle %0d] mismatch: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic void add_write(input int unsigned addr, input logic [7:0] pattern);
        wr_t w;
        w.address = addr[ADDR_W-1:0];
        w.nibble  = pattern[7:4];
        w.last    = 1'b0;
        update_writes.push_back(w);
    endfunction

    // Upper half with its extra bits first, then the low half one address up.
    function automatic void add_digit(input int unsigned addr, input logic [7:0] pat,
                                      input logic [7:0] extra);
        logic [7:0] low_half;
        low_half = pat << 4;
        add_write(addr, pat | extra);
        add_write(addr + 1, low_half);
    endfunction

    function automatic void format_update(input logic [TEMP_W-1:0] raw,
                                          input logic [LEVEL_W-1:0] lvl);
        logic        neg;
        logic        p1;
        logic        blink;
        logic [7:0]  tens_mark;
        int unsigned mag;
        int unsigned d4, d3, d2, d1;
        int unsigned a;

        neg = raw[TEMP_W-1];
        mag = neg ? (32'h10000 - 32'(raw)) : 32'(raw);
        if (mag > MAG_MAX)
            mag = 32'(MAG_MAX);
        d4 = mag / 1000;
        d3 = (mag / 100) % 10;
        d2 = (mag / 10) % 10;
        d1 = mag % 10;
        p1 = (lvl >= LEVEL_ONE) && (lvl <= LEVEL_FOUR);
        blink = (lvl == LEVEL_BLINK);

        update_writes.delete();
        for (a = 0; a < 9; a++)
            add_write(a, 8'h00);

        case (lvl)
            LEVEL_EMPTY, LEVEL_ONE, LEVEL_BLINK: add_write(8, ICON_BIT);
            LEVEL_TWO:   add_write(8, ICON_BIT | BAR_ONE);
            LEVEL_THREE: add_write(8, ICON_BIT | BAR_TWO);
            LEVEL_FOUR:  add_write(8, ICON_BIT | BAR_THREE);
            default: ;
        endcase

        add_digit(6, SEG_TABLE[d1], MARK_BIT);
        add_digit(4, SEG_TABLE[d2], unit_mark_en ? MARK_BIT : 8'h00);

        // Tens position: minus sign for small negatives, blink gating at level five.
        if (d4 == 0 && d3 == 0)
        begin
            if (neg)
            begin
                if (blink)
                begin
                    if (!blink_phase_q)
                        add_write(2, MARK_BIT | MINUS_BIT);
                    add_write(2, MINUS_BIT);
                end
                else
                    add_write(2, MARK_BIT | MINUS_BIT);
            end
            else if (!blink || !blink_phase_q)
                add_write(2, MARK_BIT);
        end
        else
        begin
            tens_mark = (!blink || blink_phase_q) ? MARK_BIT : 8'h00;
            add_digit(2, SEG_TABLE[d3], tens_mark);
        end
        blink_phase_q = ~blink_phase_q;

        if (d4 != 0)
            add_digit(0, SEG_TABLE[d4], p1 ? MARK_BIT : 8'h00);
        else if (neg && d3 != 0)
            add_write(0, MINUS_BIT | (p1 ? MARK_BIT : 8'h00));
        else if (p1)
            add_write(0, MARK_BIT);

        update_writes[update_writes.size() - 1].last = 1'b1;
        foreach (update_writes[i])
            pending_writes.push_back(update_writes[i]);
    endfunction

    // Hold push through bursts; unless sender_steady, drop it for a random gap, possibly zero, between bursts.
    task automatic send_update(input logic signed [TEMP_W-1:0] t,
                               input logic [LEVEL_W-1:0] lvl);
        int gap;
        if (!sender_steady)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                if (gap > 0)
                begin
                    push <= 1'b0;
                    temp_tenths <= TEMP_W'($urandom);
                    battery_level <= LEVEL_W'($urandom);
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 8);
            end
            burst_left--;
        end
        push <= 1'b1;
        temp_tenths <= t;
        battery_level <= lvl;
        do
            @(posedge clk);
        while (full);
        format_update(t, lvl);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_unit_mark(input logic value);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        unit_mark_en = value;
        cfg_write <= 1'b0;
    endtask

    function automatic logic signed [TEMP_W-1:0] pick_temperature();
        logic signed [TEMP_W-1:0] t;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: t = TEMP_W'($urandom_range(0, 198) - 99);
            4, 5:       t = TEMP_W'($urandom_range(0, 1998) - 999);
            6:          t = TEMP_W'($urandom_range(0, 19998) - 9999);
            7:          t = TEMP_W'($urandom);
            8:
            begin
                case ($urandom_range(0, 7))
                    0: t = TEMP_W'(-32768);
                    1: t = TEMP_W'(32767);
                    2: t = TEMP_W'(9999);
                    3: t = TEMP_W'(-9999);
                    4: t = TEMP_W'(10000);
                    5: t = TEMP_W'(-10000);
                    6: t = '0;
                    default: t = '1;
                endcase
            end
            default:    t = TEMP_W'($urandom_range(0, 300) - 150);
        endcase
        return t;
    endfunction

    // Check each accepted write against the oldest prediction, then pick the next pop.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_writes.size() == 0)
                report_mismatch($sformatf("write with none expected: addr %0d nibble %h last %b",
                                          write_address, write_nibble, last_write));
            else
            begin
                oldest_write = pending_writes.pop_front();
                if (write_address !== oldest_write.address)
                    report_mismatch($sformatf("write_address %0d, expected %0d",
                                              write_address, oldest_write.address));
                if (write_nibble !== oldest_write.nibble)
                    report_mismatch($sformatf("write_nibble %h at addr %0d, expected %h",
                                              write_nibble, oldest_write.address,
                                              oldest_write.nibble));
                if (last_write !== oldest_write.last)
                    report_mismatch($sformatf("last_write %b at addr %0d, expected %b",
                                              last_write, oldest_write.address,
                                              oldest_write.last));
            end
        end

        if (style_left == 0)
        begin
            pop_style = pop_style_e'($urandom_range(0, 3));
            style_left = $urandom_range(50, 300);
        end
        style_left--;

        if (stall_left > 0)
        begin
            pop <= 1'b0;
            stall_left--;
        end
        else
        begin
            case (pop_style)
                POP_ALWAYS:  pop <= 1'b1;
                POP_RANDOM:  pop <= ($urandom_range(0, 2) != 0);
                POP_LONG_STALLS:
                begin
                    pop <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(1, 30);
                end
                default:     pop <= ~pop;
            endcase
        end
    end

    task automatic test_directed();
        int temps [22] = '{0, 32767, -32768, -1, 9999, -9999, 10000, -10000, 5, 5, -5, -5,
                           -99, -100, -1234, 1234, -1234, 999, -999, 100, 21845, -21846};
        int levels [22] = '{0, 1, 2, 3, 4, 5, 6, 7, 5, 5, 5, 5,
                            1, 0, 4, 5, 5, 2, 6, 3, 0, 7};
        foreach (temps[i])
            send_update(TEMP_W'(temps[i]), LEVEL_W'(levels[i]));
    endtask

    task automatic test_unit_mark();
        write_unit_mark(1'b0);
        repeat (10) send_update(pick_temperature(), LEVEL_W'($urandom_range(0, 7)));
        write_unit_mark(1'b1);
        repeat (6) send_update(pick_temperature(), LEVEL_W'($urandom_range(0, 7)));
    endtask

    task automatic test_random_updates();
        int i;
        for (i = 0; i < 30; i++)
            send_update(pick_temperature(), LEVEL_W'($urandom_range(0, 7)));
        write_unit_mark(1'b0);
        // Back-to-back requests with no gaps on the sender side.
        sender_steady = 1'b1;
        for (i = 0; i < 30; i++)
            send_update(pick_temperature(), LEVEL_W'($urandom_range(0, 7)));
        sender_steady = 1'b0;
        write_unit_mark(1'b1);
        for (i = 0; i < 40; i++)
        begin
            if (i == 20)
            begin
                // Hold off until every predicted write has been drained.
                push <= 1'b0;
                @(posedge clk);
                while (pending_writes.size() != 0)
                    @(posedge clk);
            end
            send_update(pick_temperature(), LEVEL_W'($urandom_range(0, 7)));
        end
        write_unit_mark(1'b0);
        for (i = 0; i < 30; i++)
            send_update(pick_temperature(),
                        LEVEL_W'($urandom_range(LEVEL_ONE, LEVEL_BLINK)));
    endtask

    initial
    begin
        unit_mark_en = 1'b1;
        blink_phase_q = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_unit_mark();
        test_random_updates();

        wait_idle();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/segfmt_pkg.sv
sv/segfmt_queue.sv
sv/segfmt_front.sv
sv/segfmt_back.sv
sv/segment_lcd_temperature_formatter_core.sv
sv/segfmt_checker.sv
verif/tb.sv
